FILE: rtl/buddy_page_allocator_core_macros.svh
// ---------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, field types, codes and small helper functions.
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_PAGES  = 1024;
  localparam int PAGE_ORDER = 12;
  localparam int TOP_ORDER  = 22;
  localparam int NUM_LEVELS = TOP_ORDER - PAGE_ORDER + 1;
  localparam int PAGE_W     = 10;
  localparam int PCNT_W     = 11;
  localparam int LV_W       = 4;
  localparam int SLOT_DEPTH = 2 * NUM_PAGES;
  localparam int SLOT_AW    = 11;
  localparam int ADDR_W     = 22;
  localparam int SIZE_W     = 32;
  localparam int ORD_W      = 5;
  localparam int CFG_DW     = 11;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [PCNT_W-1:0]  pcnt_t;
  typedef logic [LV_W-1:0]    lv_t;
  typedef logic [SLOT_AW-1:0] slot_addr_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ORD_W-1:0]   ord_t;
  typedef logic [SIZE_W-1:0]  req_size_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_MEM   = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_START   = 2'd0,
    CFG_COUNT   = 2'd1,
    CFG_DISABLE = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_EMIT,
    S_AL_CHK, S_AL_SRCH, S_AL_POP, S_AL_SPLIT, S_AL_SETO, S_AL_MARK,
    S_FR_CHK, S_FR_RD, S_FR_MARK, S_FR_MRG, S_FR_BUD, S_FR_JOIN, S_FR_SETO,
    S_IN_BEG, S_IN_LV, S_IN_FILL,
    S_PUSH, S_SH_RD, S_SH_WR, S_ER_RD, S_ER_CMP
  } state_t;

  // per-page bookkeeping entry
  typedef struct packed {
    logic  is_free;
    logic  handed;
    lv_t   border;
    lv_t   rorder;
    page_t rstart;
  } page_ent_t;

  // per-field write enables of the page store
  typedef struct packed {
    logic is_free;
    logic handed;
    logic border;
    logic rorder;
    logic rstart;
  } page_we_t;

  // first slot of a level's queue: levels are packed back to back
  function automatic slot_addr_t level_base(lv_t lv);
    logic [SLOT_AW:0] full;
    full = (SLOT_AW+1)'(SLOT_DEPTH);
    return slot_addr_t'(full - (full >> lv));
  endfunction

  function automatic pcnt_t level_cap(lv_t lv);
    return pcnt_t'(NUM_PAGES) >> lv;
  endfunction

  // number of significant bits
  function automatic logic [5:0] bit_len(req_size_t x);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (x[i]) r = 6'(i + 1);
    end
    return r;
  endfunction

  // floor(log2(x)) for nonzero x, clamped to the top level
  function automatic lv_t floor_log2(pcnt_t x);
    lv_t r;
    r = '0;
    for (int i = 0; i < PCNT_W; i++) begin
      if (x[i]) r = lv_t'(i);
    end
    if (r > lv_t'(NUM_LEVELS - 1)) r = lv_t'(NUM_LEVELS - 1);
    return r;
  endfunction

endpackage

FILE: rtl/bpa_page_mem.sv
// ---------------------------------------------------------------------------
// Buddy page allocator page store
// One entry per page, per-field write enables, registered read.
// ---------------------------------------------------------------------------
module bpa_page_mem (
  input  logic               clk,
  input  bpa_pkg::page_we_t  we,
  input  bpa_pkg::page_t     waddr,
  input  bpa_pkg::page_ent_t wdata,
  input  bpa_pkg::page_t     raddr,
  output bpa_pkg::page_ent_t rdata
);

  logic           free_m   [bpa_pkg::NUM_PAGES];
  logic           handed_m [bpa_pkg::NUM_PAGES];
  bpa_pkg::lv_t   border_m [bpa_pkg::NUM_PAGES];
  bpa_pkg::lv_t   rorder_m [bpa_pkg::NUM_PAGES];
  bpa_pkg::page_t rstart_m [bpa_pkg::NUM_PAGES];

  always_ff @(posedge clk) begin
    if (we.is_free) free_m[waddr]   <= wdata.is_free;
    if (we.handed)  handed_m[waddr] <= wdata.handed;
    if (we.border)  border_m[waddr] <= wdata.border;
    if (we.rorder)  rorder_m[waddr] <= wdata.rorder;
    if (we.rstart)  rstart_m[waddr] <= wdata.rstart;
    rdata.is_free <= free_m[raddr];
    rdata.handed  <= handed_m[raddr];
    rdata.border  <= border_m[raddr];
    rdata.rorder  <= rorder_m[raddr];
    rdata.rstart  <= rstart_m[raddr];
  end

endmodule

FILE: rtl/bpa_slot_ram.sv
// ---------------------------------------------------------------------------
// Buddy page allocator free-queue slots
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module bpa_slot_ram (
  input  logic                clk,
  input  logic                we,
  input  bpa_pkg::slot_addr_t waddr,
  input  bpa_pkg::page_t      wdata,
  input  bpa_pkg::slot_addr_t raddr,
  output bpa_pkg::page_t      rdata
);

  bpa_pkg::page_t mem [bpa_pkg::SLOT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/buddy_page_allocator_core.sv
// ---------------------------------------------------------------------------
// Buddy page allocator core
// Sequencer over a page store and a packed set of per-order FIFO free queues.
// ---------------------------------------------------------------------------
// Reset: synchronous, active low; then a pass over every page clears the page store
//   before the first item is taken (config writes still land).
// Init: clears the page store, then marks each region page and queues each root block.
// Alloc: searches up the levels, pops the head entry and closes the gap behind it,
//   splits down to the wanted order and marks the pages. Free: marks the pages
//   touched, then merges with each free buddy, erasing it from its queue. One item
//   at a time; the page store and slot RAM, one write and one read port each, set the pace.
module buddy_page_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [bpa_pkg::SIZE_W-1:0]    in_request_size,
  input  logic [bpa_pkg::ADDR_W-1:0]    in_free_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [bpa_pkg::ADDR_W-1:0]    out_block_address,
  output logic [bpa_pkg::ORD_W-1:0]     out_block_order,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bpa_pkg::CFG_DW-1:0]    cfg_wdata
);

  `include "buddy_page_allocator_core_macros.svh"

  localparam logic [bpa_pkg::SIZE_W:0] SIZE_LIMIT =
    (bpa_pkg::SIZE_W+1)'(1) << bpa_pkg::TOP_ORDER;
  localparam bpa_pkg::req_size_t PAGE_BYTES =
    bpa_pkg::req_size_t'(1) << bpa_pkg::PAGE_ORDER;
  localparam bpa_pkg::lv_t LV_TOP = bpa_pkg::lv_t'(bpa_pkg::NUM_LEVELS - 1);
  localparam bpa_pkg::pcnt_t NP = bpa_pkg::pcnt_t'(bpa_pkg::NUM_PAGES);

  // config
  bpa_pkg::page_t start_r;
  bpa_pkg::pcnt_t count_r;
  logic           dis_r;

  // sequencer
  bpa_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  bpa_pkg::pcnt_t  idx_r, idx_nxt, end_r, end_nxt, cur_r, cur_nxt, left_r, left_nxt;
  bpa_pkg::pcnt_t  qpos_r, qpos_nxt;
  bpa_pkg::page_t  page_r, page_nxt, bud_r, bud_nxt, qpage_r, qpage_nxt;
  bpa_pkg::page_t  rstart_r, rstart_nxt;
  bpa_pkg::lv_t    lv_r, lv_nxt, want_r, want_nxt, qlv_r, qlv_nxt, rorder_r, rorder_nxt;
  bpa_pkg::ord_t   ord_r, ord_nxt;
  bpa_pkg::req_size_t size_r, size_nxt;
  bpa_pkg::addr_t  faddr_r, faddr_nxt;
  bpa_pkg::status_t res_st_r, res_st_nxt;
  bpa_pkg::addr_t  res_addr_r, res_addr_nxt;
  bpa_pkg::ord_t   res_ord_r, res_ord_nxt;

  bpa_pkg::pcnt_t  qcnt_r [bpa_pkg::NUM_LEVELS];
  logic            qcnt_we, qcnt_clr;
  bpa_pkg::pcnt_t  qcnt_wval;

  logic             out_valid_r, load_out;
  bpa_pkg::status_t out_status_r;
  bpa_pkg::addr_t   out_addr_r;
  bpa_pkg::ord_t    out_ord_r;

  // memory ports
  bpa_pkg::page_we_t   pm_we;
  bpa_pkg::page_t      pm_waddr, pm_raddr;
  bpa_pkg::page_ent_t  pm_wdata, pm_rdata;
  logic                sl_we;
  bpa_pkg::slot_addr_t sl_waddr, sl_raddr;
  bpa_pkg::page_t      sl_wdata, sl_rdata;

  // shared arithmetic
  bpa_pkg::pcnt_t      cnt, cap, sz, want_sz, in_sz, avail;
  bpa_pkg::slot_addr_t base;
  bpa_pkg::page_t      rel;
  logic [bpa_pkg::PAGE_W+1:0] bud_w;
  logic                bud_ok, run_ok;
  bpa_pkg::ord_t       ord_calc;
  bpa_pkg::lv_t        in_lv;
  logic [16:0]         fr_end;

  bpa_page_mem u_page_mem (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  bpa_slot_ram u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  assign cnt     = qcnt_r[qlv_r];
  assign cap     = bpa_pkg::level_cap(qlv_r);
  assign base    = bpa_pkg::level_base(qlv_r);
  assign sz      = bpa_pkg::pcnt_t'(1) << lv_r;
  assign want_sz = bpa_pkg::pcnt_t'(1) << want_r;
  assign rel     = page_r - rstart_r;
  // buddy sits below when the block is the right half within its root
  assign bud_w   = ((rel & sz[bpa_pkg::PAGE_W-1:0]) != '0)
                 ? {2'b00, page_r} - {1'b0, sz}
                 : {2'b00, page_r} + {1'b0, sz};
  assign bud_ok  = bud_w < (bpa_pkg::PAGE_W+2)'(bpa_pkg::NUM_PAGES);
  assign run_ok  = (idx_r < end_r) && (idx_r < NP);
  assign ord_calc = (size_r <= PAGE_BYTES) ? bpa_pkg::ord_t'(bpa_pkg::PAGE_ORDER)
                  : bpa_pkg::ord_t'(bpa_pkg::bit_len(size_r - 1'b1));
  assign in_lv   = bpa_pkg::floor_log2(left_r);
  assign in_sz   = bpa_pkg::pcnt_t'(1) << in_lv;
  assign avail   = NP - {1'b0, start_r};
  assign fr_end  = {7'd0, page_r} + (17'(1) << pm_rdata.border);

  always_comb begin
    state_nxt  = state_r;   ret_nxt   = ret_r;
    idx_nxt    = idx_r;     end_nxt   = end_r;
    cur_nxt    = cur_r;     left_nxt  = left_r;
    qpos_nxt   = qpos_r;    page_nxt  = page_r;
    bud_nxt    = bud_r;     qpage_nxt = qpage_r;
    rstart_nxt = rstart_r;  rorder_nxt = rorder_r;
    lv_nxt     = lv_r;      want_nxt  = want_r;
    qlv_nxt    = qlv_r;     ord_nxt   = ord_r;
    size_nxt   = size_r;    faddr_nxt = faddr_r;
    res_st_nxt = res_st_r;  res_addr_nxt = res_addr_r;
    res_ord_nxt = res_ord_r;
    qcnt_we    = 1'b0;      qcnt_clr  = 1'b0;
    qcnt_wval  = cnt;
    pm_we      = '0;
    pm_waddr   = idx_r[bpa_pkg::PAGE_W-1:0];
    pm_wdata   = '0;
    pm_raddr   = page_r;
    sl_we      = 1'b0;
    sl_waddr   = base + bpa_pkg::slot_addr_t'(qpos_r);
    sl_wdata   = qpage_r;
    sl_raddr   = base + bpa_pkg::slot_addr_t'(qpos_r);
    in_ready   = 1'b0;
    load_out   = 1'b0;

    unique case (state_r)
      bpa_pkg::S_CLR: begin
        pm_we   = '1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == NP - 1'b1) begin
          idx_nxt   = '0;
          state_nxt = ret_r;
        end
      end

      bpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          size_nxt     = in_request_size;
          faddr_nxt    = in_free_address;
          res_st_nxt   = bpa_pkg::ST_OK;
          res_addr_nxt = '0;
          res_ord_nxt  = '0;
          unique case (bpa_pkg::op_t'(in_operation))
            bpa_pkg::OP_ALLOC: state_nxt = bpa_pkg::S_AL_CHK;
            bpa_pkg::OP_FREE:  state_nxt = bpa_pkg::S_FR_CHK;
            bpa_pkg::OP_INIT: begin
              qcnt_clr  = 1'b1;
              idx_nxt   = '0;
              ret_nxt   = bpa_pkg::S_IN_BEG;
              state_nxt = bpa_pkg::S_CLR;
            end
            bpa_pkg::OP_NOP:   state_nxt = bpa_pkg::S_EMIT;
            default:           state_nxt = bpa_pkg::S_EMIT;
          endcase
        end
      end

      bpa_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = bpa_pkg::S_IDLE;
        end
      end

      // ---------------- allocate ----------------
      bpa_pkg::S_AL_CHK: begin
        priority if (dis_r) begin
          res_st_nxt = bpa_pkg::ST_NO_MEM;
          state_nxt  = bpa_pkg::S_EMIT;
        end else if (size_r == '0 || {1'b0, size_r} > SIZE_LIMIT) begin
          res_st_nxt = bpa_pkg::ST_BAD_SIZE;
          state_nxt  = bpa_pkg::S_EMIT;
        end else begin
          ord_nxt   = ord_calc;
          want_nxt  = bpa_pkg::lv_t'(ord_calc - bpa_pkg::ord_t'(bpa_pkg::PAGE_ORDER));
          qlv_nxt   = bpa_pkg::lv_t'(ord_calc - bpa_pkg::ord_t'(bpa_pkg::PAGE_ORDER));
          state_nxt = bpa_pkg::S_AL_SRCH;
        end
      end

      bpa_pkg::S_AL_SRCH: begin
        if (cnt != '0) begin
          lv_nxt    = qlv_r;
          sl_raddr  = base;
          state_nxt = bpa_pkg::S_AL_POP;
        end else if (qlv_r == LV_TOP) begin
          res_st_nxt = bpa_pkg::ST_NO_MEM;
          state_nxt  = bpa_pkg::S_EMIT;
        end else begin
          qlv_nxt = qlv_r + 1'b1;
        end
      end

      bpa_pkg::S_AL_POP: begin
        page_nxt  = sl_rdata;
        qpos_nxt  = '0;
        ret_nxt   = bpa_pkg::S_AL_SPLIT;
        state_nxt = bpa_pkg::S_SH_RD;
      end

      bpa_pkg::S_AL_SPLIT: begin
        if (lv_r > want_r) begin
          idx_nxt   = {1'b0, page_r} + (sz >> 1);
          end_nxt   = {1'b0, page_r} + sz;
          qpage_nxt = page_r + bpa_pkg::page_t'(sz >> 1);
          state_nxt = bpa_pkg::S_AL_SETO;
        end else begin
          idx_nxt   = {1'b0, page_r};
          end_nxt   = {1'b0, page_r} + want_sz;
          state_nxt = bpa_pkg::S_AL_MARK;
        end
      end

      // right half takes the next lower order, then goes on its queue
      bpa_pkg::S_AL_SETO: begin
        if (run_ok) begin
          pm_we.border    = 1'b1;
          pm_wdata.border = lv_r - 1'b1;
          idx_nxt         = idx_r + 1'b1;
        end else begin
          qlv_nxt   = lv_r - 1'b1;
          lv_nxt    = lv_r - 1'b1;
          ret_nxt   = bpa_pkg::S_AL_SPLIT;
          state_nxt = bpa_pkg::S_PUSH;
        end
      end

      bpa_pkg::S_AL_MARK: begin
        if (run_ok) begin
          pm_we.is_free   = 1'b1;
          pm_we.border    = 1'b1;
          pm_wdata.border = want_r;
          idx_nxt         = idx_r + 1'b1;
        end else begin
          pm_we.handed    = 1'b1;
          pm_waddr        = page_r;
          pm_wdata.handed = 1'b1;
          res_addr_nxt    = bpa_pkg::addr_t'({page_r, {bpa_pkg::PAGE_ORDER{1'b0}}});
          res_ord_nxt     = ord_r;
          state_nxt       = bpa_pkg::S_EMIT;
        end
      end

      // ---------------- free ----------------
      bpa_pkg::S_FR_CHK: begin
        if (faddr_r[bpa_pkg::PAGE_ORDER-1:0] != '0) begin
          res_st_nxt = bpa_pkg::ST_BAD_FREE;
          state_nxt  = bpa_pkg::S_EMIT;
        end else begin
          page_nxt  = faddr_r[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_ORDER];
          pm_raddr  = faddr_r[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_ORDER];
          state_nxt = bpa_pkg::S_FR_RD;
        end
      end

      bpa_pkg::S_FR_RD: begin
        if (pm_rdata.is_free || !pm_rdata.handed) begin
          res_st_nxt = bpa_pkg::ST_BAD_FREE;
          state_nxt  = bpa_pkg::S_EMIT;
        end else begin
          pm_we.handed = 1'b1;
          pm_waddr     = page_r;
          lv_nxt       = pm_rdata.border;
          rorder_nxt   = pm_rdata.rorder;
          rstart_nxt   = pm_rdata.rstart;
          idx_nxt      = {1'b0, page_r};
          end_nxt      = (fr_end > 17'(bpa_pkg::NUM_PAGES)) ? NP : bpa_pkg::pcnt_t'(fr_end);
          state_nxt    = bpa_pkg::S_FR_MARK;
        end
      end

      bpa_pkg::S_FR_MARK: begin
        if (run_ok) begin
          pm_we.is_free    = 1'b1;
          pm_wdata.is_free = 1'b1;
          idx_nxt          = idx_r + 1'b1;
        end else begin
          state_nxt = bpa_pkg::S_FR_MRG;
        end
      end

      bpa_pkg::S_FR_MRG: begin
        if (lv_r >= rorder_r || lv_r >= LV_TOP || !bud_ok) begin
          qlv_nxt   = lv_r;
          qpage_nxt = page_r;
          ret_nxt   = bpa_pkg::S_EMIT;
          state_nxt = bpa_pkg::S_PUSH;
        end else begin
          bud_nxt   = bud_w[bpa_pkg::PAGE_W-1:0];
          pm_raddr  = bud_w[bpa_pkg::PAGE_W-1:0];
          state_nxt = bpa_pkg::S_FR_BUD;
        end
      end

      bpa_pkg::S_FR_BUD: begin
        qlv_nxt = lv_r;
        if (!pm_rdata.is_free || pm_rdata.border != lv_r) begin
          qpage_nxt = page_r;
          ret_nxt   = bpa_pkg::S_EMIT;
          state_nxt = bpa_pkg::S_PUSH;
        end else begin
          qpage_nxt = bud_r;
          qpos_nxt  = '0;
          ret_nxt   = bpa_pkg::S_FR_JOIN;
          state_nxt = bpa_pkg::S_ER_RD;
        end
      end

      bpa_pkg::S_FR_JOIN: begin
        if (bud_r < page_r) begin
          page_nxt = bud_r;
          idx_nxt  = {1'b0, bud_r};
          end_nxt  = {1'b0, bud_r} + (sz << 1);
        end else begin
          idx_nxt  = {1'b0, page_r};
          end_nxt  = {1'b0, page_r} + (sz << 1);
        end
        lv_nxt    = lv_r + 1'b1;
        state_nxt = bpa_pkg::S_FR_SETO;
      end

      bpa_pkg::S_FR_SETO: begin
        if (run_ok) begin
          pm_we.border    = 1'b1;
          pm_wdata.border = lv_r;
          idx_nxt         = idx_r + 1'b1;
        end else begin
          state_nxt = bpa_pkg::S_FR_MRG;
        end
      end

      // ---------------- init ----------------
      bpa_pkg::S_IN_BEG: begin
        cur_nxt   = {1'b0, start_r};
        left_nxt  = (count_r > avail) ? avail : count_r;
        state_nxt = bpa_pkg::S_IN_LV;
      end

      bpa_pkg::S_IN_LV: begin
        if (left_r == '0) begin
          state_nxt = bpa_pkg::S_EMIT;
        end else begin
          lv_nxt    = in_lv;
          idx_nxt   = cur_r;
          end_nxt   = cur_r + in_sz;
          state_nxt = bpa_pkg::S_IN_FILL;
        end
      end

      bpa_pkg::S_IN_FILL: begin
        if (run_ok) begin
          pm_we            = '1;
          pm_wdata.is_free = 1'b1;
          pm_wdata.border  = lv_r;
          pm_wdata.rorder  = lv_r;
          pm_wdata.rstart  = cur_r[bpa_pkg::PAGE_W-1:0];
          idx_nxt          = idx_r + 1'b1;
        end else begin
          qlv_nxt   = lv_r;
          qpage_nxt = cur_r[bpa_pkg::PAGE_W-1:0];
          cur_nxt   = cur_r + sz;
          left_nxt  = left_r - sz;
          ret_nxt   = bpa_pkg::S_IN_LV;
          state_nxt = bpa_pkg::S_PUSH;
        end
      end

      // ---------------- queue ops on level qlv_r ----------------
      bpa_pkg::S_PUSH: begin
        if (cnt < cap) begin
          sl_we     = 1'b1;
          sl_waddr  = base + bpa_pkg::slot_addr_t'(cnt);
          qcnt_we   = 1'b1;
          qcnt_wval = cnt + 1'b1;
        end
        state_nxt = ret_r;
      end

      // close the gap at qpos_r, reading each following entry and writing it one slot down
      bpa_pkg::S_SH_RD: begin
        if (qpos_r + 1'b1 < cnt) begin
          sl_raddr  = base + bpa_pkg::slot_addr_t'(qpos_r + 1'b1);
          state_nxt = bpa_pkg::S_SH_WR;
        end else begin
          qcnt_we   = 1'b1;
          qcnt_wval = cnt - 1'b1;
          state_nxt = ret_r;
        end
      end

      bpa_pkg::S_SH_WR: begin
        sl_we     = 1'b1;
        sl_wdata  = sl_rdata;
        qpos_nxt  = qpos_r + 1'b1;
        state_nxt = bpa_pkg::S_SH_RD;
      end

      bpa_pkg::S_ER_RD: begin
        if (qpos_r < cnt) begin
          state_nxt = bpa_pkg::S_ER_CMP;
        end else begin
          state_nxt = ret_r;
        end
      end

      bpa_pkg::S_ER_CMP: begin
        if (sl_rdata == qpage_r) begin
          state_nxt = bpa_pkg::S_SH_RD;
        end else begin
          qpos_nxt  = qpos_r + 1'b1;
          state_nxt = bpa_pkg::S_ER_RD;
        end
      end

      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_CLR;
      ret_r       <= bpa_pkg::S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      count_r     <= NP;
      dis_r       <= 1'b0;
      for (int i = 0; i < bpa_pkg::NUM_LEVELS; i++) qcnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      idx_r   <= idx_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (bpa_pkg::cfg_idx_t'(cfg_index))
          bpa_pkg::CFG_START:   start_r <= cfg_wdata[bpa_pkg::PAGE_W-1:0];
          bpa_pkg::CFG_COUNT:   count_r <= cfg_wdata[bpa_pkg::PCNT_W-1:0];
          bpa_pkg::CFG_DISABLE: dis_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (qcnt_clr) begin
        for (int i = 0; i < bpa_pkg::NUM_LEVELS; i++) qcnt_r[i] <= '0;
      end else if (qcnt_we) begin
        qcnt_r[qlv_r] <= qcnt_wval;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    cur_r      <= cur_nxt;
    left_r     <= left_nxt;
    qpos_r     <= qpos_nxt;
    page_r     <= page_nxt;
    bud_r      <= bud_nxt;
    qpage_r    <= qpage_nxt;
    rstart_r   <= rstart_nxt;
    rorder_r   <= rorder_nxt;
    lv_r       <= lv_nxt;
    want_r     <= want_nxt;
    qlv_r      <= qlv_nxt;
    ord_r      <= ord_nxt;
    size_r     <= size_nxt;
    faddr_r    <= faddr_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    res_ord_r  <= res_ord_nxt;
    if (load_out) begin
      out_status_r <= res_st_r;
      out_addr_r   <= res_addr_r;
      out_ord_r    <= res_ord_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_block_order   = out_ord_r;

  `BPA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted but block stayed ready")
  `BPA_ASSERT_IMP(a_push_room, sl_we && (state_r == bpa_pkg::S_PUSH), cnt < cap, "queue push past capacity")
  `BPA_ASSERT_IMP(a_idle_quiet, state_r == bpa_pkg::S_IDLE, !sl_we && (pm_we == '0), "memory write while idle")
  `BPA_ASSERT_IMP(a_search_level, state_r == bpa_pkg::S_AL_SRCH, qlv_r <= LV_TOP, "free list search past top order")

endmodule

FILE: tb/buddy_page_allocator_core_tb.sv
// ---------------------------------------------------------------------------
// Buddy page allocator core testbench
// Random and directed alloc/free/init items against an in-bench buddy model;
// results checked in order, field by field, under random sender/receiver idling.
// ---------------------------------------------------------------------------
module buddy_page_allocator_core_tb;

  typedef struct {
    bpa_pkg::op_t       op;
    bpa_pkg::req_size_t size;
    bpa_pkg::addr_t     faddr;
  } alloc_req_t;

  typedef struct {
    bpa_pkg::status_t st;
    bpa_pkg::addr_t   addr;
    bpa_pkg::ord_t    ord;
  } grant_t;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [bpa_pkg::SIZE_W-1:0] in_request_size = '0;
  logic [bpa_pkg::ADDR_W-1:0] in_free_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [bpa_pkg::ADDR_W-1:0] out_block_address;
  logic [bpa_pkg::ORD_W-1:0] out_block_order;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [bpa_pkg::CFG_DW-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  buddy_page_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_request_size(in_request_size),
    .in_free_address(in_free_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_block_address(out_block_address),
    .out_block_order(out_block_order),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // ---------------- buddy model ----------------
  int unsigned reg_start, reg_count, reg_disable;
  bit          pg_free   [bpa_pkg::NUM_PAGES];
  bit          pg_handed [bpa_pkg::NUM_PAGES];
  int unsigned pg_border [bpa_pkg::NUM_PAGES];
  int unsigned pg_rorder [bpa_pkg::NUM_PAGES];
  int unsigned pg_rstart [bpa_pkg::NUM_PAGES];
  int unsigned free_list [bpa_pkg::NUM_LEVELS][$];
  bpa_pkg::addr_t live_blocks[$];

  function automatic void list_push(int unsigned lv, int unsigned pg);
    if (lv < bpa_pkg::NUM_LEVELS && free_list[lv].size() < (bpa_pkg::NUM_PAGES >> lv))
      free_list[lv].insert(free_list[lv].size(), pg);
  endfunction

  function automatic void list_erase(int unsigned lv, int unsigned pg);
    for (int i = 0; i < free_list[lv].size(); i++) begin
      if (free_list[lv][i] == pg) begin
        free_list[lv].delete(i);
        return;
      end
    end
  endfunction

  function automatic void relabel(int unsigned first, int unsigned n, int unsigned lv);
    for (int unsigned i = first; i < first + n && i < bpa_pkg::NUM_PAGES; i++)
      pg_border[i] = lv;
  endfunction

  function automatic void wipe_pages();
    for (int i = 0; i < bpa_pkg::NUM_PAGES; i++) begin
      pg_free[i] = 0; pg_handed[i] = 0;
      pg_border[i] = 0; pg_rorder[i] = 0; pg_rstart[i] = 0;
    end
    for (int l = 0; l < bpa_pkg::NUM_LEVELS; l++) free_list[l].delete();
  endfunction

  function automatic void carve_region();
    int unsigned cur, left, lv, sz;
    cur = reg_start;
    left = reg_count;
    wipe_pages();
    live_blocks.delete();
    if (cur >= bpa_pkg::NUM_PAGES) return;
    if (left > bpa_pkg::NUM_PAGES - cur) left = bpa_pkg::NUM_PAGES - cur;
    while (left != 0) begin
      lv = 0;
      while (lv + 1 < bpa_pkg::NUM_LEVELS && (2 << lv) <= left) lv++;
      sz = 1 << lv;
      for (int unsigned i = cur; i < cur + sz; i++) begin
        pg_free[i] = 1; pg_border[i] = lv; pg_rorder[i] = lv; pg_rstart[i] = cur;
      end
      list_push(lv, cur);
      cur += sz;
      left -= sz;
    end
  endfunction

  function automatic grant_t grant_block(bpa_pkg::req_size_t size);
    grant_t g;
    int unsigned ord, want, lv, p, half;
    g = '{bpa_pkg::ST_OK, '0, '0};
    if (reg_disable != 0) begin g.st = bpa_pkg::ST_NO_MEM; return g; end
    if (size == 0 || 64'(size) > (64'd1 << bpa_pkg::TOP_ORDER)) begin
      g.st = bpa_pkg::ST_BAD_SIZE;
      return g;
    end
    ord = bpa_pkg::PAGE_ORDER;
    while (ord < bpa_pkg::TOP_ORDER && (64'd1 << ord) < 64'(size)) ord++;
    want = ord - bpa_pkg::PAGE_ORDER;
    lv = want;
    while (lv < bpa_pkg::NUM_LEVELS && free_list[lv].size() == 0) lv++;
    if (lv >= bpa_pkg::NUM_LEVELS) begin g.st = bpa_pkg::ST_NO_MEM; return g; end
    p = free_list[lv][0];
    free_list[lv].delete(0);
    while (lv > want) begin
      half = 1 << (lv - 1);
      relabel(p + half, half, lv - 1);
      list_push(lv - 1, p + half);
      lv--;
    end
    for (int unsigned i = p; i < p + (1 << want) && i < bpa_pkg::NUM_PAGES; i++) begin
      pg_free[i] = 0; pg_border[i] = want;
    end
    if (p < bpa_pkg::NUM_PAGES) pg_handed[p] = 1;
    g.addr = bpa_pkg::addr_t'(p << bpa_pkg::PAGE_ORDER);
    g.ord = bpa_pkg::ord_t'(ord);
    return g;
  endfunction

  function automatic grant_t release_block(bpa_pkg::addr_t a);
    grant_t g;
    int unsigned p, lv, sz, rel, bud;
    g = '{bpa_pkg::ST_OK, '0, '0};
    if (a[bpa_pkg::PAGE_ORDER-1:0] != 0 ||
        (a >> bpa_pkg::PAGE_ORDER) >= bpa_pkg::NUM_PAGES) begin
      g.st = bpa_pkg::ST_BAD_FREE;
      return g;
    end
    p = a >> bpa_pkg::PAGE_ORDER;
    if (pg_free[p] || !pg_handed[p]) begin g.st = bpa_pkg::ST_BAD_FREE; return g; end
    pg_handed[p] = 0;
    lv = pg_border[p];
    for (int unsigned i = p; i < p + (1 << lv) && i < bpa_pkg::NUM_PAGES; i++)
      pg_free[i] = 1;
    forever begin
      if (lv >= pg_rorder[p] || lv + 1 >= bpa_pkg::NUM_LEVELS) begin
        list_push(lv, p);
        break;
      end
      sz = 1 << lv;
      rel = p - pg_rstart[p];
      bud = (rel & sz) ? p - sz : p + sz;
      if (bud >= bpa_pkg::NUM_PAGES || !pg_free[bud] || pg_border[bud] != lv) begin
        list_push(lv, p);
        break;
      end
      list_erase(lv, bud);
      if (bud < p) p = bud;
      relabel(p, 2 * sz, lv + 1);
      lv++;
    end
    return g;
  endfunction

  // ---------------- item queues ----------------
  alloc_req_t pending_items[$];
  grant_t     expected_grants[$];
  int errors = 0;

  task automatic queue_item(bpa_pkg::op_t op, bpa_pkg::req_size_t size,
                            bpa_pkg::addr_t faddr);
    grant_t g;
    g = '{bpa_pkg::ST_OK, '0, '0};
    case (op)
      bpa_pkg::OP_ALLOC: begin
        g = grant_block(size);
        if (g.st == bpa_pkg::ST_OK) live_blocks.insert(live_blocks.size(), g.addr);
      end
      bpa_pkg::OP_FREE: begin
        g = release_block(faddr);
        if (g.st == bpa_pkg::ST_OK)
          foreach (live_blocks[i]) if (live_blocks[i] == faddr) begin
            live_blocks.delete(i);
            break;
          end
      end
      bpa_pkg::OP_INIT: carve_region();
      default: ;
    endcase
    pending_items.insert(pending_items.size(), '{op, size, faddr});
    expected_grants.insert(expected_grants.size(), g);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bpa_pkg::cfg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= bpa_pkg::CFG_DW'(val);
    case (idx)
      bpa_pkg::CFG_START: reg_start = val & 10'h3ff;
      bpa_pkg::CFG_COUNT: reg_count = val & 11'h7ff;
      default:            reg_disable = val & 1;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bpa_pkg::req_size_t pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4 * 4096);
    if (r < 85) return $urandom_range(1, 1 << 18);
    if (r < 95) return $urandom_range(1, 1 << bpa_pkg::TOP_ORDER);
    return $urandom();
  endfunction

  task automatic random_phase(int n);
    int unsigned r, k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) queue_item(bpa_pkg::OP_ALLOC, pick_size(), bpa_pkg::addr_t'($urandom()));
      else if (r < 85 && live_blocks.size() != 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        queue_item(bpa_pkg::OP_FREE, $urandom(), live_blocks[k]);
      end else if (r < 90)
        queue_item(bpa_pkg::OP_FREE, $urandom(), bpa_pkg::addr_t'($urandom()));
      else if (r < 93 && live_blocks.size() != 0)
        queue_item(bpa_pkg::OP_FREE, $urandom(),
                   live_blocks[0] | bpa_pkg::addr_t'($urandom_range(1, 4095)));
      else if (r < 96)
        queue_item(bpa_pkg::OP_INIT, $urandom(), bpa_pkg::addr_t'($urandom()));
      else if (r < 98)
        queue_item(bpa_pkg::OP_NOP, $urandom(), bpa_pkg::addr_t'($urandom()));
      else queue_item(bpa_pkg::OP_ALLOC, pick_size(), '0);
    end
  endtask

  // ---------------- driver ----------------
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    alloc_req_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items[0];
        pending_items.delete(0);
        in_valid <= 1'b1;
        in_operation <= it.op;
        in_request_size <= it.size;
        in_free_address <= it.faddr;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver and checker ----------------
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int pattern_cnt = 0;
  int unsigned ready_mode = 0;
  always @(posedge clk) begin
    grant_t g;
    if (out_valid && out_ready && rst_n) begin
      if (expected_grants.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d addr %h order %0d",
                   out_status, out_block_address, out_block_order);
      end else begin
        g = expected_grants[0];
        expected_grants.delete(0);
        if (out_status != g.st || out_block_address != g.addr || out_block_order != g.ord) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp status %0d addr %h order %0d, got %0d %h %0d",
                     g.st, g.addr, g.ord, out_status, out_block_address, out_block_order);
        end
      end
    end
    pattern_cnt <= pattern_cnt + 1;
    if (pattern_cnt % 64 == 0) ready_mode <= $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** buddy_page_allocator_core: FAILED **");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    reg_start = 0;
    reg_count = 1024;
    reg_disable = 0;
    wipe_pages();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of the size field, bad frees, idle op, full-memory grant
    queue_item(bpa_pkg::OP_ALLOC, 32'd4096, '0);
    queue_item(bpa_pkg::OP_INIT, 32'hffff_ffff, 22'h3f_ffff);
    queue_item(bpa_pkg::OP_ALLOC, 32'd0, '0);
    queue_item(bpa_pkg::OP_ALLOC, 32'hffff_ffff, '0);
    queue_item(bpa_pkg::OP_ALLOC, (32'd1 << bpa_pkg::TOP_ORDER) + 1, '0);
    queue_item(bpa_pkg::OP_ALLOC, 32'd1, '0);
    queue_item(bpa_pkg::OP_ALLOC, 32'd4097, '0);
    queue_item(bpa_pkg::OP_ALLOC, 32'd65536, '0);
    queue_item(bpa_pkg::OP_FREE, '0, 22'h000_001);
    queue_item(bpa_pkg::OP_FREE, '0, 22'h3f_f000);
    queue_item(bpa_pkg::OP_FREE, '0, 22'h000_000);
    queue_item(bpa_pkg::OP_FREE, '0, 22'h000_000);
    queue_item(bpa_pkg::OP_FREE, '0, 22'h001_000);
    queue_item(bpa_pkg::OP_FREE, '0, 22'h002_000);
    queue_item(bpa_pkg::OP_FREE, '0, 22'h010_000);
    queue_item(bpa_pkg::OP_NOP, 32'hffff_ffff, 22'h3f_ffff);
    queue_item(bpa_pkg::OP_ALLOC, 32'd1 << bpa_pkg::TOP_ORDER, '0);
    queue_item(bpa_pkg::OP_ALLOC, 32'd1, '0);
    queue_item(bpa_pkg::OP_FREE, '0, 22'h000_000);
    queue_item(bpa_pkg::OP_ALLOC, 32'd1 << bpa_pkg::TOP_ORDER, '0);
    queue_item(bpa_pkg::OP_FREE, 32'hffff_ffff, 22'h000_000);
    wait_idle();

    write_reg(bpa_pkg::CFG_DISABLE, 1);
    queue_item(bpa_pkg::OP_INIT, '0, '0);
    queue_item(bpa_pkg::OP_ALLOC, 32'd0, '0);
    queue_item(bpa_pkg::OP_ALLOC, 32'd4096, '0);
    wait_idle();

    write_reg(bpa_pkg::CFG_DISABLE, 0);
    write_reg(bpa_pkg::CFG_START, 1023);
    write_reg(bpa_pkg::CFG_COUNT, 1024);
    queue_item(bpa_pkg::OP_INIT, '0, '0);
    random_phase(60);
    wait_idle();

    write_reg(bpa_pkg::CFG_START, 5);
    write_reg(bpa_pkg::CFG_COUNT, 1000);
    queue_item(bpa_pkg::OP_INIT, '0, '0);
    random_phase(300);
    hold_requests = hold_requests + 1;
    random_phase(40);
    wait_idle();

    write_reg(bpa_pkg::CFG_START, 700);
    write_reg(bpa_pkg::CFG_COUNT, 0);
    queue_item(bpa_pkg::OP_INIT, '0, '0);
    random_phase(30);
    wait_idle();

    write_reg(bpa_pkg::CFG_START, 0);
    write_reg(bpa_pkg::CFG_COUNT, 2047);
    queue_item(bpa_pkg::OP_INIT, '0, '0);
    random_phase(350);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(bpa_pkg::CFG_START, $urandom_range(0, 1023));
      write_reg(bpa_pkg::CFG_COUNT, $urandom_range(0, 1024));
      write_reg(bpa_pkg::CFG_DISABLE, ($urandom_range(0, 4) == 0));
      queue_item(bpa_pkg::OP_INIT, '0, '0);
      random_phase(200);
      wait_idle();
    end

    if (errors == 0 && expected_grants.size() == 0) begin
      $display("** buddy_page_allocator_core: PASSED **");
    end else begin
      $display("** buddy_page_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
